/* sv/nwaf_pkg.sv */
// Package for the next weekly alarm finder.
// Holds the alarm entry type, request kind codes and time constants.
// No dependencies.
`default_nettype none

package nwaf_pkg;

  // Default table depth.
  localparam int unsigned NumAlarmsDef = 8;

  // Time constants.
  localparam int unsigned MinsPerHour     = 60;
  localparam int unsigned HoursPerDay     = 24;
  localparam int unsigned DaysPerWeek     = 7;
  localparam int unsigned MinsPerDay      = HoursPerDay * MinsPerHour;
  localparam int unsigned MaxMinutesUntil = 10079;

  // Width of a minute-of-day value built from raw 5-bit hour and 6-bit minute.
  localparam int unsigned MinsW = 11;
  // Width of the reported distance.
  localparam int unsigned DistW = 14;

  // Request kinds carried on the input tuser bit.
  typedef enum logic {
    FuncWrite = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  // One stored alarm.
  typedef struct packed {
    logic       enable;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] day_bits;
  } alarm_entry_t;

  // Raw hour and minute folded into minutes since midnight (hour * 60 + minute).
  function automatic logic [MinsW-1:0] mins_of_day(input logic [4:0] hour,
                                                   input logic [5:0] minute);
    logic [MinsW-1:0] h;
    h = {6'b0, hour};
    return (h << 6) - (h << 2) + {5'b0, minute};
  endfunction

  // Minutes in a whole number of days, for offsets of zero to seven days.
  function automatic logic [DistW-1:0] day_minutes(input logic [2:0] off);
    logic [DistW-1:0] r;
    case (off)
      3'd0:    r = DistW'(0);
      3'd1:    r = DistW'(MinsPerDay);
      3'd2:    r = DistW'(2 * MinsPerDay);
      3'd3:    r = DistW'(3 * MinsPerDay);
      3'd4:    r = DistW'(4 * MinsPerDay);
      3'd5:    r = DistW'(5 * MinsPerDay);
      3'd6:    r = DistW'(6 * MinsPerDay);
      3'd7:    r = DistW'(7 * MinsPerDay);
      default: r = DistW'(0);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/nwaf_alarm_mem.sv */
// Alarm table storage: one write port, one registered read port.
// Each entry has a valid bit cleared by reset; an unwritten entry reads as disabled.
// Depends on nwaf_pkg.
`default_nettype none

module nwaf_alarm_mem
  import nwaf_pkg::*;
#(
  parameter int unsigned NUM_ALARMS = NumAlarmsDef,
  localparam int unsigned IdxW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [IdxW-1:0]     waddr_i,
  input  wire alarm_entry_t        wdata_i,
  input  wire logic [IdxW-1:0]     raddr_i,
  output alarm_entry_t             rdata_o
);

  alarm_entry_t            mem_q [NUM_ALARMS];
  logic [NUM_ALARMS-1:0]   valid_q;
  alarm_entry_t            rd_entry_q;
  logic                    rd_valid_q;

  // Entry storage and read data register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_entry_q <= mem_q[raddr_i];
  end

  // Per-entry valid bits and the valid flag of the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  // An entry never written reads as all zero, which is a disabled alarm.
  assign rdata_o = rd_valid_q ? rd_entry_q : '0;

endmodule

`default_nettype wire

/* sv/nwaf_dist_unit.sv */
// Distance unit: minutes until the next occurrence of one alarm entry.
// Shared by every table entry during a query scan. Depends on nwaf_pkg.
`default_nettype none

module nwaf_dist_unit
  import nwaf_pkg::*;
(
  input  wire alarm_entry_t       entry_i,
  input  wire logic [2:0]         today_i,    // 0 to 6
  input  wire logic [MinsW-1:0]   now_mins_i,
  output logic                    hit_o,
  output logic [DistW-1:0]        dist_o
);

  logic [MinsW-1:0]   a_mins;
  logic [6:0]         rot;
  logic [2:0]         off;
  logic [DistW-1:0]   day_m;
  logic signed [15:0] raw;

  assign a_mins = mins_of_day(entry_i.hour, entry_i.minute);

  // Rotate the weekday mask so that bit k stands for today plus k days.
  always_comb begin
    logic [3:0] pos;
    pos = '0;
    for (int k = 0; k < 7; k++) begin
      pos = {1'b0, today_i} + 4'(k);
      if (pos >= 4'(DaysPerWeek)) begin
        pos = pos - 4'(DaysPerWeek);
      end
      rot[k] = entry_i.day_bits[pos[2:0]];
    end
  end

  // Find the first day offset with an occurrence not yet passed.
  always_comb begin
    hit_o = 1'b0;
    off   = 3'd0;
    if (entry_i.enable) begin
      if (rot[0] && (a_mins >= now_mins_i)) begin
        hit_o = 1'b1;
        off   = 3'd0;
      end else begin
        for (int k = 6; k >= 1; k--) begin
          if (rot[k]) begin
            hit_o = 1'b1;
            off   = 3'(k);
          end
        end
        // Passed today and set for no other day: same time next week.
        if (!hit_o && rot[0]) begin
          hit_o = 1'b1;
          off   = 3'(DaysPerWeek);
        end
      end
    end
  end

  assign day_m = day_minutes(off);

  // Signed distance, saturated to the reportable range.
  always_comb begin
    raw = $signed({2'b0, day_m}) + $signed({5'b0, a_mins}) - $signed({5'b0, now_mins_i});
    if (raw < 0) begin
      dist_o = '0;
    end else if (raw > 16'sd10079) begin
      dist_o = DistW'(MaxMinutesUntil);
    end else begin
      dist_o = raw[DistW-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/next_weekly_alarm_finder.sv */
// Next weekly alarm finder: stores weekly alarms and finds the nearest enabled one.
// A write request stores the entry and returns an all-zero result; a query walks the
// table one entry per cycle through the distance unit and reports the nearest hit.
// The input is not ready while a request is in work, so a new request is taken only
// after the last result has been loaded into the output register.
// Reset (rst_ni low, asynchronous) disables every alarm and empties the output register.
`default_nettype none

module next_weekly_alarm_finder
  import nwaf_pkg::*;
#(
  parameter int unsigned NUM_ALARMS = NumAlarmsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: slot[2:0], enable[3], hour[8:4], minute[14:9], day_bits[21:15],
  //        weekday[24:22], zero fill [31:25]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: func[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: alarm_index[2:0], minutes_until[16:3], zero fill [23:17]
  output logic [23:0]      m_axis_tdata,
  // tuser: found[0]
  output logic             m_axis_tuser
);

  localparam int unsigned IdxW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int unsigned CntW = $clog2(NUM_ALARMS + 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  // Input field unpacking.
  logic [2:0]   in_slot;
  logic         in_enable;
  logic [4:0]   in_hour;
  logic [5:0]   in_minute;
  logic [6:0]   in_days;
  logic [2:0]   in_weekday;
  func_e        in_func;

  assign in_slot    = s_axis_tdata[2:0];
  assign in_enable  = s_axis_tdata[3];
  assign in_hour    = s_axis_tdata[8:4];
  assign in_minute  = s_axis_tdata[14:9];
  assign in_days    = s_axis_tdata[21:15];
  assign in_weekday = s_axis_tdata[24:22];
  assign in_func    = func_e'(s_axis_tuser);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pipe_vld_q, pipe_vld_d;
  logic [IdxW-1:0]     pipe_idx_q, pipe_idx_d;
  logic [2:0]          today_q, today_d;
  logic [MinsW-1:0]    now_q, now_d;
  logic                found_q, found_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic [DistW-1:0]    best_q, best_d;
  logic                out_vld_q, out_vld_d;
  logic                out_found_q, out_found_d;
  logic [2:0]          out_idx_q, out_idx_d;
  logic [DistW-1:0]    out_mins_q, out_mins_d;

  logic                mem_we;
  alarm_entry_t        mem_wdata;
  alarm_entry_t        rd_entry;
  logic                hit;
  logic [DistW-1:0]    cand_mins;
  logic                slot_ok;

  assign mem_wdata = '{enable: in_enable, hour: in_hour, minute: in_minute,
                       day_bits: in_days};
  assign slot_ok   = ({4'b0, in_slot} < 7'(NUM_ALARMS));

  // Alarm table.
  nwaf_alarm_mem #(
    .NUM_ALARMS(NUM_ALARMS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (IdxW'(in_slot)),
    .wdata_i (mem_wdata),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  // Shared distance unit, fed one entry per cycle.
  nwaf_dist_unit u_dist (
    .entry_i    (rd_entry),
    .today_i    (today_q),
    .now_mins_i (now_q),
    .hit_o      (hit),
    .dist_o     (cand_mins)
  );

  assign s_axis_tready = (state_q == StIdle);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pipe_vld_d  = 1'b0;
    pipe_idx_d  = pipe_idx_q;
    today_d     = today_q;
    now_d       = now_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    out_vld_d   = out_vld_q & ~m_axis_tready;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_mins_d  = out_mins_q;
    mem_we      = 1'b0;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          found_d    = 1'b0;
          best_idx_d = '0;
          best_d     = '0;
          if (in_func == FuncQuery) begin
            // Weekday seven behaves as weekday zero.
            today_d = (in_weekday == 3'd7) ? 3'd0 : in_weekday;
            now_d   = mins_of_day(in_hour, in_minute);
            cnt_d   = '0;
            state_d = StScan;
          end else begin
            mem_we  = slot_ok;
            state_d = StDone;
          end
        end
      end
      StScan: begin
        // Issue one table read per cycle; the read data comes back in the following cycle.
        if (cnt_q != CntW'(NUM_ALARMS)) begin
          pipe_vld_d = 1'b1;
          pipe_idx_d = cnt_q[IdxW-1:0];
          cnt_d      = cnt_q + 1'b1;
        end
        // Strictly smaller wins, so the lowest index keeps a tie.
        if (pipe_vld_q && hit && (!found_q || (cand_mins < best_q))) begin
          found_d    = 1'b1;
          best_idx_d = pipe_idx_q;
          best_d     = cand_mins;
        end
        if ((cnt_q == CntW'(NUM_ALARMS)) && !pipe_vld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Load the output register once it is free.
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d   = 1'b1;
          out_found_d = found_q;
          out_idx_d   = 3'(best_idx_q);
          out_mins_d  = best_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      pipe_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pipe_vld_q <= pipe_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pipe_idx_q  <= pipe_idx_d;
    today_q     <= today_d;
    now_q       <= now_d;
    found_q     <= found_d;
    best_idx_q  <= best_idx_d;
    best_q      <= best_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
    out_mins_q  <= out_mins_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {7'b0, out_mins_q, out_idx_q};

endmodule

`default_nettype wire

/* test/nwaf_alarm_checker.sv */
// Checker for the next weekly alarm finder: watches both stream channels,
// predicts the answer to every request and compares it with the result.
// Depends on nwaf_pkg for the alarm entry type, request kinds and time constants.
`timescale 1ns / 100ps

module nwaf_alarm_checker
  import nwaf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  // tdata: slot[2:0], enable[3], hour[8:4], minute[14:9], day_bits[21:15],
  //        weekday[24:22], zero fill [31:25]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: func[0]
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: alarm_index[2:0], minutes_until[16:3], zero fill [23:17]
  input  wire logic [23:0] m_axis_tdata,
  // tuser: found[0]
  input  wire logic        m_axis_tuser,
  output int               fail_count_o,
  output int               pending_o
);

  // One answer as the block should report it.
  typedef struct packed {
    logic        found;
    logic [2:0]  index;
    logic [13:0] mins;
  } answer_t;

  // Our own copy of the alarm table and the answers still owed.
  alarm_entry_t alarm_shadow [NumAlarmsDef];
  answer_t      expected_answers [$];

  initial fail_count_o = 0;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  // Nearest enabled alarm occurrence seen from the given weekday and time.
  function automatic answer_t nearest_alarm(input logic [2:0] wday, input logic [4:0] hr,
                                            input logic [5:0] mn);
    answer_t      best;
    alarm_entry_t entry;
    int           now_m;
    int           alarm_m;
    int           today;
    int           day;
    int           cand_mins;
    bit           hit;
    best  = '0;
    now_m = int'(hr) * int'(MinsPerHour) + int'(mn);
    today = int'(wday) % int'(DaysPerWeek);
    for (int i = 0; i < NumAlarmsDef; i++) begin
      entry     = alarm_shadow[i];
      alarm_m   = int'(entry.hour) * int'(MinsPerHour) + int'(entry.minute);
      hit       = 1'b0;
      cand_mins = 0;
      if (entry.enable) begin
        // Walk today and the next seven days; today counts only if not yet passed.
        for (int off = 0; off <= int'(DaysPerWeek) && !hit; off++) begin
          day = (today + off) % int'(DaysPerWeek);
          if (entry.day_bits[day] && !(off == 0 && alarm_m < now_m)) begin
            hit       = 1'b1;
            cand_mins = off * int'(MinsPerDay) + alarm_m - now_m;
            if (cand_mins < 0) cand_mins = 0;
            if (cand_mins > int'(MaxMinutesUntil)) cand_mins = int'(MaxMinutesUntil);
          end
        end
      end
      // Strictly nearer only, so the lowest index keeps a tie.
      if (hit && (!best.found || cand_mins < int'(best.mins))) begin
        best.found = 1'b1;
        best.index = 3'(i);
        best.mins  = 14'(cand_mins);
      end
    end
    return best;
  endfunction

  // Compare finished results, then fold in newly accepted requests.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    answer_t got;
    if (!rst_ni) begin
      foreach (alarm_shadow[i]) alarm_shadow[i] = '0;
      expected_answers.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{found: m_axis_tuser, index: m_axis_tdata[2:0], mins: m_axis_tdata[16:3]};
        if (expected_answers.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting (found %0d index %0d mins %0d)",
                                    got.found, got.index, got.mins));
        end else begin
          want = expected_answers.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found %0d, expected %0d", got.found, want.found));
          if (got.index !== want.index)
            report_mismatch($sformatf("alarm_index %0d, expected %0d", got.index, want.index));
          if (got.mins !== want.mins)
            report_mismatch($sformatf("minutes_until %0d, expected %0d", got.mins, want.mins));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (func_e'(s_axis_tuser) == FuncQuery) begin
          expected_answers.push_back(nearest_alarm(s_axis_tdata[24:22], s_axis_tdata[8:4],
                                                   s_axis_tdata[14:9]));
        end else begin
          alarm_shadow[s_axis_tdata[2:0]] = '{enable: s_axis_tdata[3],
                                              hour: s_axis_tdata[8:4],
                                              minute: s_axis_tdata[14:9],
                                              day_bits: s_axis_tdata[21:15]};
          expected_answers.push_back('0);
        end
      end
      pending_o <= expected_answers.size();
    end
  end

endmodule

/* test/tb_next_weekly_alarm_finder.sv */
// Testbench top for the next weekly alarm finder: clock, reset, request stimulus,
// result back-pressure and the final verdict.
// Depends on nwaf_pkg, next_weekly_alarm_finder and nwaf_alarm_checker.
`timescale 1ns / 100ps

module tb_next_weekly_alarm_finder;
  import nwaf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count;
  int          pending;

  // Sender burst bookkeeping and the request for a long receiver hold-off.
  int          burst_left;
  bit          hold_off_req;
  // Alarm times last written per slot, used to aim queries at exact hits.
  logic [4:0]  written_hour [8];
  logic [5:0]  written_minute [8];

  next_weekly_alarm_finder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  nwaf_alarm_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one request and wait for it to be accepted. Gaps fall between bursts.
  task automatic send_request(input func_e f, input logic [2:0] slot, input logic en,
                              input logic [4:0] hr, input logic [5:0] mn,
                              input logic [6:0] mask, input logic [2:0] wday);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {7'b0, wday, mask, mn, hr, en, slot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Write one alarm entry; the weekday field is ignored and left random.
  task automatic store_alarm(input logic [2:0] slot, input logic en, input logic [4:0] hr,
                             input logic [5:0] mn, input logic [6:0] mask);
    written_hour[slot]   = hr;
    written_minute[slot] = mn;
    send_request(FuncWrite, slot, en, hr, mn, mask, 3'($urandom_range(0, 7)));
  endtask

  // Ask for the next alarm; slot, enable and mask are ignored and left random.
  task automatic ask_next(input logic [2:0] wday, input logic [4:0] hr, input logic [5:0] mn);
    send_request(FuncQuery, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), hr, mn,
                 7'($urandom_range(0, 127)), wday);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly legal hours and minutes, with the raw out-of-range values now and then.
  function automatic logic [4:0] pick_hour();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23));
  endfunction

  function automatic logic [5:0] pick_minute();
    return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63)) : 6'($urandom_range(0, 59));
  endfunction

  function automatic logic [6:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return 7'h00;
      1:       return 7'h7f;
      2:       return 7'(1 << $urandom_range(0, 6));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [2:0] pick_weekday();
    return ($urandom_range(0, 7) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
  endfunction

  // Reset, directed requests, random requests, then the verdict.
  initial begin
    logic [2:0] s;
    logic [4:0] hr;
    logic [5:0] mn;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FuncWrite;
    burst_left    = 0;
    hold_off_req  = 1'b0;
    foreach (written_hour[i]) begin
      written_hour[i]   = '0;
      written_minute[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: nothing found.
    ask_next(3'd0, 5'd0, 6'd0);
    // Daily alarm: ahead today, exactly now, just passed.
    store_alarm(3'd0, 1'b1, 5'd7, 6'd30, 7'h7f);
    ask_next(3'd3, 5'd7, 6'd0);
    ask_next(3'd3, 5'd7, 6'd30);
    ask_next(3'd3, 5'd7, 6'd31);
    // Alarm set only for today that has passed counts next week.
    store_alarm(3'd1, 1'b1, 5'd6, 6'd0, 7'b0000100);
    store_alarm(3'd0, 1'b0, 5'd7, 6'd30, 7'h7f);
    ask_next(3'd2, 5'd6, 6'd1);
    ask_next(3'd2, 5'd5, 6'd59);
    // Two alarms at the same time: the lower index wins.
    store_alarm(3'd5, 1'b1, 5'd12, 6'd0, 7'h7f);
    store_alarm(3'd3, 1'b1, 5'd12, 6'd0, 7'h7f);
    ask_next(3'd4, 5'd11, 6'd0);
    // Raw out-of-range times, weekday seven, and a distance that clamps to zero.
    store_alarm(3'd6, 1'b1, 5'd31, 6'd63, 7'b0000001);
    store_alarm(3'd7, 1'b1, 5'd0, 6'd0, 7'b0000010);
    ask_next(3'd7, 5'd0, 6'd0);
    ask_next(3'd6, 5'd31, 6'd63);
    ask_next(3'd0, 5'd31, 6'd63);
    // Enabled with no days, and disabled entries, never match.
    store_alarm(3'd2, 1'b1, 5'd0, 6'd0, 7'h00);
    store_alarm(3'd4, 1'b0, 5'd23, 6'd59, 7'h7f);
    // All ignored fields at their maximum on both kinds of request, then at zero on a query.
    send_request(FuncQuery, 3'd7, 1'b1, 5'd31, 6'd63, 7'h7f, 3'd7);
    send_request(FuncWrite, 3'd7, 1'b1, 5'd31, 6'd63, 7'h7f, 3'd7);
    send_request(FuncQuery, 3'd0, 1'b0, 5'd23, 6'd59, 7'h00, 3'd6);
    ask_next(3'd0, 5'd0, 6'd0);
    drain_results();

    // Random traffic: writes mixed with queries, some aimed at stored times.
    for (int i = 0; i < 1430; i++) begin
      if (i == 600) hold_off_req = 1'b1;
      if (i > 0 && i % 350 == 0) drain_results();
      s = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 35) begin
        store_alarm(s, 1'($urandom_range(0, 4) != 0), pick_hour(), pick_minute(), pick_mask());
      end else if ($urandom_range(0, 9) < 4) begin
        hr = written_hour[s];
        mn = written_minute[s];
        case ($urandom_range(0, 2))
          0:       if (mn != 6'd0) mn = mn - 6'd1;
          1:       if (mn != 6'd63) mn = mn + 6'd1;
          default: ;
        endcase
        ask_next(pick_weekday(), hr, mn);
      end else begin
        ask_next(pick_weekday(), pick_hour(), pick_minute());
      end
    end

    // Let the checker count the last accepted request before waiting on it.
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result back-pressure: changing stall patterns plus one long hold-off on request.
  initial begin
    int mode;
    int left;
    int phase;
    m_axis_tready <= 1'b0;
    left  = 0;
    mode  = 0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 150);
      end
      left--;
      phase++;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (phase % 7 < 2);
      endcase
    end
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #1_500_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/nwaf_pkg.sv
sv/nwaf_alarm_mem.sv
sv/nwaf_dist_unit.sv
sv/next_weekly_alarm_finder.sv
test/nwaf_alarm_checker.sv
test/tb_next_weekly_alarm_finder.sv
